// ===== rtl/core/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// scp_pkg: shared definitions for the serial command parser
// Field widths, command letters, parser codes, register indexes and the
// constants of the timer reload conversion.
// ----------------------------------------------------------------------------
package scp_pkg;

    // Timing and default values
    localparam int unsigned TIMEOUT_MS          = 100;
    localparam int unsigned TIMER_CLOCK_MHZ     = 240;
    localparam int unsigned DEFAULT_PERIOD_MS   = 100;
    localparam int unsigned DEFAULT_INTERVAL_NS = 1000;
    localparam int unsigned NS_PER_US           = 1000;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int TIME_W     = 32;
    localparam int PERIOD_W   = 8;
    localparam int INTERVAL_W = 16;
    localparam int RELOAD_W   = 14;
    localparam int STATE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 48;

    localparam logic [RELOAD_W-1:0] RELOAD_MAX = {RELOAD_W{1'b1}};

    // Parser state codes
    localparam logic [STATE_W-1:0] PS_IDLE     = 2'd0;
    localparam logic [STATE_W-1:0] PS_PERIOD   = 2'd1;
    localparam logic [STATE_W-1:0] PS_INTERVAL = 2'd2;

    // Command letters
    localparam logic [BYTE_W-1:0] CMD_PERIOD   = 8'h66; // 'f'
    localparam logic [BYTE_W-1:0] CMD_STOP     = 8'h70; // 'p'
    localparam logic [BYTE_W-1:0] CMD_RUN      = 8'h72; // 'r'
    localparam logic [BYTE_W-1:0] CMD_TRIGGER  = 8'h74; // 't'
    localparam logic [BYTE_W-1:0] CMD_INTERVAL = 8'h64; // 'd'

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MAX = 2'd3;

    // Reload conversion: ticks = floor(dt * MHz / 1000), done as one constant
    // multiply by MHz * ceil(2^SHIFT / 1000) followed by a right shift.
    localparam int unsigned     RECIP_SHIFT = 36;
    localparam longint unsigned RECIP_MUL   =
        ((64'd1 << RECIP_SHIFT) + 64'(NS_PER_US) - 64'd1) / 64'(NS_PER_US);
    localparam longint unsigned RELOAD_MUL  = RECIP_MUL * 64'(TIMER_CLOCK_MHZ);
    localparam int RELOAD_MUL_W = $clog2(RELOAD_MUL + 64'd1);
    localparam int PROD_W       = INTERVAL_W + RELOAD_MUL_W;
    localparam int TICKS_W      = PROD_W - RECIP_SHIFT;

endpackage

// ===== rtl/core/scp_reload.sv =====
// ----------------------------------------------------------------------------
// scp_reload: sample interval to timer reload conversion
// reload = floor(dt * MHz / 1000) - 1, floored at zero, saturated to 14 bits.
// ----------------------------------------------------------------------------
module scp_reload
    import scp_pkg::*;
(
    input  logic [INTERVAL_W-1:0] interval_ns,
    output logic [RELOAD_W-1:0]   reload_value
);

    logic [PROD_W-1:0]  prod;
    logic [TICKS_W-1:0] ticks;
    logic [TICKS_W-1:0] ticks_m1;

    // Scale by the reciprocal and keep the integer part
    assign prod     = PROD_W'(interval_ns) * PROD_W'(RELOAD_MUL);
    assign ticks    = prod[PROD_W-1:RECIP_SHIFT];
    assign ticks_m1 = ticks - TICKS_W'(1);

    // Floor at zero, saturate at the top of the reload range
    always_comb begin
        if (ticks == '0) begin
            reload_value = '0;
        end else if (32'(ticks_m1) > 32'(RELOAD_MAX)) begin
            reload_value = RELOAD_MAX;
        end else begin
            reload_value = RELOAD_W'(ticks_m1);
        end
    end

endmodule

// ===== rtl/core/serial_command_parser_top.sv =====
// ----------------------------------------------------------------------------
// serial_command_parser_top: serial command parser
// Decodes single-letter commands from received bytes into run control,
// period, sample interval and timer reload settings.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat on s_* carries one received byte with its millisecond
// timestamp (s_tuser low) or a clear of the single-trigger request
// (s_tuser high). Every input beat yields exactly one output beat on m_*
// with the settings as they stand after that beat and a reload write flag.
// Period and interval limits are written through cfg_wr_en/cfg_index/cfg_data;
// the user must do so only while no beat is in flight; the block has no guard.
// From the input register a beat moves to the parser stage register, which feeds
// the reload multiply and the output register that drives m_tvalid.
// Throughput is one beat per cycle while m_tready stays high; each stage holds its
// own beat, so a beat may be accepted while a finished result waits on m_tready.
// When the receiver stalls, the stall backs up stage by stage until
// s_tready drops; nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline, puts the parser in
// idle, stops runs, clears the trigger request and the reload, and loads
// the default period, interval and limits.
// ----------------------------------------------------------------------------
module serial_command_parser_top
    import scp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // rx_byte[7:0], now_ms[39:8]
    input  logic                  s_tuser,   // kind[0]
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // run_active[0], single_request[1],
                                             // period_ms[9:2], interval_ns[25:10],
                                             // reload_write[26], reload_value[40:27],
                                             // parse_state[42:41], zero[47:43]
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [PERIOD_W-1:0]   period_min_reg;
    logic [PERIOD_W-1:0]   period_max_reg;
    logic [INTERVAL_W-1:0] interval_min_reg;
    logic [INTERVAL_W-1:0] interval_max_reg;

    // Input stage
    logic                  in_valid_reg;
    logic                  in_kind_reg;
    logic [BYTE_W-1:0]     in_byte_reg;
    logic [TIME_W-1:0]     in_now_reg;

    // Parser state
    logic [STATE_W-1:0]    state_reg, state_next;
    logic                  byte_idx_reg, byte_idx_next;
    logic [BYTE_W-1:0]     low_byte_reg, low_byte_next;
    logic [TIME_W-1:0]     last_ms_reg, last_ms_next;
    logic                  run_reg, run_next;
    logic                  single_reg, single_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic [INTERVAL_W-1:0] interval_reg, interval_next;
    logic                  strobe_next;

    // Parser stage output
    logic                  mid_valid_reg;
    logic                  mid_run_reg;
    logic                  mid_single_reg;
    logic [PERIOD_W-1:0]   mid_period_reg;
    logic [INTERVAL_W-1:0] mid_interval_reg;
    logic                  mid_strobe_reg;
    logic [STATE_W-1:0]    mid_state_reg;

    // Output stage
    logic                  out_valid_reg;
    logic                  out_run_reg;
    logic                  out_single_reg;
    logic [PERIOD_W-1:0]   out_period_reg;
    logic [INTERVAL_W-1:0] out_interval_reg;
    logic                  out_strobe_reg;
    logic [RELOAD_W-1:0]   out_reload_reg;
    logic [STATE_W-1:0]    out_state_reg;
    logic [RELOAD_W-1:0]   reload_reg, reload_next;
    logic [RELOAD_W-1:0]   reload_calc;

    logic                  out_ready;
    logic                  mid_ready;
    logic                  in_ready;
    logic                  in_adv;
    logic                  mid_adv;
    logic                  out_adv;
    logic                  timed_out;
    logic [INTERVAL_W-1:0] dt;

    // Stage handshakes: a stage takes a beat when it is empty or drains
    assign out_ready = !out_valid_reg || m_tready;
    assign mid_ready = !mid_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || mid_ready;
    assign s_tready  = in_ready;
    assign in_adv    = s_tvalid && in_ready;
    assign mid_adv   = in_valid_reg && mid_ready;
    assign out_adv   = mid_valid_reg && out_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_min_reg   <= PERIOD_W'(1);
            period_max_reg   <= PERIOD_W'(255);
            interval_min_reg <= INTERVAL_W'(100);
            interval_max_reg <= INTERVAL_W'(65535);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PERIOD_MIN:   period_min_reg   <= cfg_data[PERIOD_W-1:0];
                CFG_PERIOD_MAX:   period_max_reg   <= cfg_data[PERIOD_W-1:0];
                CFG_INTERVAL_MIN: interval_min_reg <= cfg_data;
                CFG_INTERVAL_MAX: interval_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: valid under reset, payload without
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv) begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata[BYTE_W-1:0];
            in_now_reg  <= s_tdata[BYTE_W +: TIME_W];
        end
    end

    // Parser next state
    assign timed_out = (state_reg != PS_IDLE) &&
                       ((in_now_reg - last_ms_reg) > TIME_W'(TIMEOUT_MS));
    assign dt        = {in_byte_reg, low_byte_reg};

    always_comb begin
        logic [STATE_W-1:0] cur_state;
        logic               cur_idx;
        cur_state     = state_reg;
        cur_idx       = byte_idx_reg;
        state_next    = state_reg;
        byte_idx_next = byte_idx_reg;
        low_byte_next = low_byte_reg;
        last_ms_next  = last_ms_reg;
        run_next      = run_reg;
        single_next   = single_reg;
        period_next   = period_reg;
        interval_next = interval_reg;
        strobe_next   = 1'b0;
        if (in_kind_reg) begin
            // clear event touches the trigger request only
            single_next = 1'b0;
        end else begin
            // abandon a stale partial command before decoding
            if (timed_out) begin
                cur_state = PS_IDLE;
                cur_idx   = 1'b0;
            end
            last_ms_next  = in_now_reg;
            state_next    = cur_state;
            byte_idx_next = cur_idx;
            case (cur_state)
                PS_IDLE: begin
                    case (in_byte_reg)
                        CMD_PERIOD:   state_next = PS_PERIOD;
                        CMD_STOP:     run_next = 1'b0;
                        CMD_RUN:      run_next = 1'b1;
                        CMD_TRIGGER:  single_next = 1'b1;
                        CMD_INTERVAL: begin
                            state_next    = PS_INTERVAL;
                            byte_idx_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
                PS_PERIOD: begin
                    if (in_byte_reg >= period_min_reg && in_byte_reg <= period_max_reg) begin
                        period_next = in_byte_reg;
                    end
                    state_next = PS_IDLE;
                end
                PS_INTERVAL: begin
                    if (!cur_idx) begin
                        low_byte_next = in_byte_reg;
                        byte_idx_next = 1'b1;
                    end else begin
                        if (dt >= interval_min_reg && dt <= interval_max_reg) begin
                            interval_next = dt;
                            strobe_next   = 1'b1;
                        end
                        byte_idx_next = 1'b0;
                        state_next    = PS_IDLE;
                    end
                end
                default: begin
                    state_next = PS_IDLE;
                end
            endcase
        end
    end

    // Parser state registers advance with each beat leaving the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= PS_IDLE;
            byte_idx_reg <= 1'b0;
            low_byte_reg <= '0;
            last_ms_reg  <= '0;
            run_reg      <= 1'b0;
            single_reg   <= 1'b0;
            period_reg   <= PERIOD_W'(DEFAULT_PERIOD_MS);
            interval_reg <= INTERVAL_W'(DEFAULT_INTERVAL_NS);
        end else if (mid_adv) begin
            state_reg    <= state_next;
            byte_idx_reg <= byte_idx_next;
            low_byte_reg <= low_byte_next;
            last_ms_reg  <= last_ms_next;
            run_reg      <= run_next;
            single_reg   <= single_next;
            period_reg   <= period_next;
            interval_reg <= interval_next;
        end
    end

    // Parser stage result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else if (mid_ready) begin
            mid_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_adv) begin
            mid_run_reg      <= run_next;
            mid_single_reg   <= single_next;
            mid_period_reg   <= period_next;
            mid_interval_reg <= interval_next;
            mid_strobe_reg   <= strobe_next;
            mid_state_reg    <= state_next;
        end
    end

    // Reload conversion of a newly accepted interval
    scp_reload u_reload (
        .interval_ns  (mid_interval_reg),
        .reload_value (reload_calc)
    );

    assign reload_next = mid_strobe_reg ? reload_calc : reload_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg <= '0;
        end else if (out_adv) begin
            reload_reg <= reload_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv) begin
            out_run_reg      <= mid_run_reg;
            out_single_reg   <= mid_single_reg;
            out_period_reg   <= mid_period_reg;
            out_interval_reg <= mid_interval_reg;
            out_strobe_reg   <= mid_strobe_reg;
            out_reload_reg   <= reload_next;
            out_state_reg    <= mid_state_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_state_reg, out_reload_reg, out_strobe_reg,
                       out_interval_reg, out_period_reg, out_single_reg, out_run_reg};

endmodule
